[sv/nps_pkg.sv]
// Shared types and constants for the nearest point search block.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package nps_pkg;

   localparam int COORD_W = 24;
   localparam int TAG_W   = 16;

   localparam logic [1:0] FUNC_CLEAR  = 2'd0;
   localparam logic [1:0] FUNC_APPEND = 2'd1;
   localparam logic [1:0] FUNC_FIND   = 2'd2;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_EMPTY = 2'd1;
   localparam logic [1:0] STATUS_FULL  = 2'd2;

   typedef struct packed {
      logic [1:0]                func;
      logic signed [COORD_W-1:0] pos_x;
      logic signed [COORD_W-1:0] pos_y;
      logic [TAG_W-1:0]          point_tag;
   } req_type;

   typedef struct packed {
      logic [1:0]                status;
      logic [5:0]                entry_index;
      logic [TAG_W-1:0]          entry_tag;
      logic signed [COORD_W-1:0] entry_x;
      logic signed [COORD_W-1:0] entry_y;
      logic [6:0]                point_count;
   } rsp_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic [TAG_W-1:0]          tag;
   } point_type;

   // Control from the sequencer to the distance unit.
   typedef struct packed {
      logic start;   // new query: forget the current best
      logic step;    // head point this cycle is a live entry
   } scan_ctl_type;

endpackage

[sv/nps_cell.sv]
// One storage cell of the point ring: holds one point and its tag.
// Depends on nps_pkg.
`timescale 1ns / 1ps

module nps_cell (
   input  logic               clock,
   input  logic               load,
   input  logic               shift,
   input  nps_pkg::point_type load_point,
   input  nps_pkg::point_type next_point,
   output nps_pkg::point_type point
);
   import nps_pkg::*;

   point_type point_ff;
   point_type point_in;

   // Load a new point, or advance from the neighbor while the ring turns.
   always_comb begin
      point_in = point_ff;
      if (load) begin
         point_in = load_point;
      end else if (shift) begin
         point_in = next_point;
      end
   end

   always_ff @(posedge clock) begin
      point_ff <= point_in;
   end

   assign point = point_ff;

endmodule

[sv/nps_dist.sv]
// Three-stage squared-distance unit with running best-match tracker.
// Depends on nps_pkg.
`timescale 1ns / 1ps

module nps_dist #(
   parameter int IDX_W = 6
) (
   input  logic                              clock,
   input  logic                              reset,
   input  nps_pkg::scan_ctl_type             ctl,
   input  logic [IDX_W-1:0]                  head_idx,
   input  nps_pkg::point_type                head_point,
   input  logic signed [nps_pkg::COORD_W-1:0] query_x,
   input  logic signed [nps_pkg::COORD_W-1:0] query_y,
   output nps_pkg::point_type                best_point,
   output logic [IDX_W-1:0]                  best_idx
);
   import nps_pkg::*;

   localparam int SQ_W = 2 * COORD_W;

   // stage 1: absolute differences
   logic                      v1_ff;
   logic [IDX_W-1:0]          idx1_ff;
   point_type                 p1_ff;
   logic [COORD_W-1:0]        adx_ff, ady_ff;
   logic [COORD_W-1:0]        adx_in, ady_in;
   logic signed [COORD_W:0]   dx, dy, dx_neg, dy_neg;

   // stage 2: squares
   logic                      v2_ff;
   logic [IDX_W-1:0]          idx2_ff;
   point_type                 p2_ff;
   logic [SQ_W-1:0]           sqx_ff, sqy_ff;
   logic [SQ_W-1:0]           sqx_in, sqy_in;

   // stage 3: sum, compare, keep best
   logic [SQ_W:0]             sum;
   logic                      take;
   logic                      have_ff;
   logic [SQ_W:0]             best_d_ff;
   logic [IDX_W-1:0]          best_idx_ff;
   point_type                 best_p_ff;

   always_comb begin
      dx     = {head_point.x[COORD_W-1], head_point.x} - {query_x[COORD_W-1], query_x};
      dy     = {head_point.y[COORD_W-1], head_point.y} - {query_y[COORD_W-1], query_y};
      dx_neg = -dx;
      dy_neg = -dy;
      adx_in = dx[COORD_W] ? dx_neg[COORD_W-1:0] : dx[COORD_W-1:0];
      ady_in = dy[COORD_W] ? dy_neg[COORD_W-1:0] : dy[COORD_W-1:0];
      sqx_in = SQ_W'(adx_ff) * SQ_W'(adx_ff);
      sqy_in = SQ_W'(ady_ff) * SQ_W'(ady_ff);
      sum    = {1'b0, sqx_ff} + {1'b0, sqy_ff};
      // strictly closer only, so the earliest entry wins a tie
      take   = v2_ff && (!have_ff || (sum < best_d_ff));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff   <= 1'b0;
         v2_ff   <= 1'b0;
         have_ff <= 1'b0;
      end else begin
         v1_ff <= ctl.step;
         v2_ff <= v1_ff;
         if (ctl.start) begin
            have_ff <= 1'b0;
         end else if (take) begin
            have_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      idx1_ff <= head_idx;
      p1_ff   <= head_point;
      adx_ff  <= adx_in;
      ady_ff  <= ady_in;
      idx2_ff <= idx1_ff;
      p2_ff   <= p1_ff;
      sqx_ff  <= sqx_in;
      sqy_ff  <= sqy_in;
      if (take) begin
         best_d_ff   <= sum;
         best_idx_ff <= idx2_ff;
         best_p_ff   <= p2_ff;
      end
   end

   assign best_point = best_p_ff;
   assign best_idx   = best_idx_ff;

endmodule

[sv/nearest_point_search.sv]
// Top level of the nearest point search block: sequencer, point ring, result register.
// Depends on nps_pkg, nps_cell and nps_dist.
`timescale 1ns / 1ps

// Usage
//   req channel (req_valid / req_stall / req_data): one beat per command.
//   func clear empties the table, append stores a point at the next free
//   index, find returns the stored point nearest to (pos_x, pos_y).
//   rsp channel (rsp_valid / rsp_stall / rsp_data): exactly one beat per
//   request, in request order, carrying status and the count after the item.
// Sequence
//   Clear, append and the unused code: the sequencer passes its done state,
//   which registers the result once the output is free. Find: the point ring
//   turns once, and the head point runs through a three-stage distance unit;
//   the sequencer drains those stages before the done state registers the
//   result. An empty-table find skips the scan. One item at a time;
//   req_stall is high until the result is queued.
// Reset
//   Synchronous reset empties the table and drops any pending beat. Point
//   storage is not cleared; entries at or above the count are never read.
// Backpressure
//   While rsp_stall is high the result beat holds; a finished item waits in
//   the sequencer, and a new request may be taken once the result is queued.
module nearest_point_search #(
   parameter int MAX_POINTS = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  nps_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output nps_pkg::rsp_type rsp_data
);
   import nps_pkg::*;

   localparam int CNT_W = $clog2(MAX_POINTS + 1);
   localparam int IDX_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_SCAN  = 4'b0010,
      ST_DRAIN = 4'b0100,
      ST_DONE  = 4'b1000
   } state_type;

   state_type                 state_ff, state_in;
   logic [CNT_W-1:0]          count_ff, count_in;
   logic [IDX_W-1:0]          sc_ff, sc_in;
   logic                      drain_ff, drain_in;
   logic [1:0]                pend_status_ff, pend_status_in;
   logic                      pend_find_ff, pend_find_in;
   logic signed [COORD_W-1:0] qx_ff, qy_ff;
   logic                      rsp_valid_ff, rsp_valid_in;
   rsp_type                   rsp_ff, rsp_in;

   logic                      req_accept;
   logic                      table_full;
   logic                      append_go;
   logic                      ring_shift;
   logic                      rsp_free;
   scan_ctl_type              ctl;
   point_type                 new_point;
   point_type                 ring [MAX_POINTS];
   point_type                 best_point;
   logic [IDX_W-1:0]          best_idx;

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign table_full = (count_ff == CNT_W'(MAX_POINTS));
   assign append_go  = req_accept && (req_data.func == FUNC_APPEND) && !table_full;
   assign ring_shift = (state_ff == ST_SCAN);
   assign rsp_free   = !rsp_valid_ff || !rsp_stall;

   assign new_point.x   = req_data.pos_x;
   assign new_point.y   = req_data.pos_y;
   assign new_point.tag = req_data.point_tag;

   // Ring of point cells: cell 0 is the head that feeds the distance unit,
   // each cell takes its upper neighbor while the ring turns.
   for (genvar i = 0; i < MAX_POINTS; i++) begin : g_cell
      nps_cell u_cell (
         .clock      (clock),
         .load       (append_go && (count_ff == CNT_W'(i))),
         .shift      (ring_shift),
         .load_point (new_point),
         .next_point (ring[(i + 1) % MAX_POINTS]),
         .point      (ring[i])
      );
   end

   // Entry sc_ff sits at the head during scan step sc_ff.
   assign ctl.start = req_accept && (req_data.func == FUNC_FIND);
   assign ctl.step  = ring_shift && (CNT_W'(sc_ff) < count_ff);

   nps_dist #(
      .IDX_W (IDX_W)
   ) u_dist (
      .clock      (clock),
      .reset      (reset),
      .ctl        (ctl),
      .head_idx   (sc_ff),
      .head_point (ring[0]),
      .query_x    (qx_ff),
      .query_y    (qy_ff),
      .best_point (best_point),
      .best_idx   (best_idx)
   );

   always_comb begin
      state_in       = state_ff;
      count_in       = count_ff;
      sc_in          = sc_ff;
      drain_in       = drain_ff;
      pend_status_in = pend_status_ff;
      pend_find_in   = pend_find_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_in         = rsp_ff;

      // drop the result beat once taken
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               pend_status_in = STATUS_OK;
               pend_find_in   = 1'b0;
               state_in       = ST_DONE;
               case (req_data.func)
                  FUNC_CLEAR: begin
                     count_in = '0;
                  end
                  FUNC_APPEND: begin
                     if (table_full) begin
                        pend_status_in = STATUS_FULL;
                     end else begin
                        count_in = count_ff + CNT_W'(1);
                     end
                  end
                  FUNC_FIND: begin
                     if (count_ff == '0) begin
                        pend_status_in = STATUS_EMPTY;
                     end else begin
                        pend_find_in = 1'b1;
                        sc_in        = '0;
                        state_in     = ST_SCAN;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SCAN: begin
            // advance one entry a cycle until the ring is back in place
            if (sc_ff == IDX_W'(MAX_POINTS - 1)) begin
               drain_in = 1'b0;
               state_in = ST_DRAIN;
            end else begin
               sc_in = sc_ff + IDX_W'(1);
            end
         end
         ST_DRAIN: begin
            // wait for the last entry to clear the distance stages
            drain_in = 1'b1;
            if (drain_ff) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in          = 1'b1;
               rsp_in.status         = pend_status_ff;
               rsp_in.point_count    = 7'(count_ff);
               rsp_in.entry_index    = '0;
               rsp_in.entry_tag      = '0;
               rsp_in.entry_x        = '0;
               rsp_in.entry_y        = '0;
               if (pend_find_ff) begin
                  rsp_in.entry_index = 6'(best_idx);
                  rsp_in.entry_tag   = best_point.tag;
                  rsp_in.entry_x     = best_point.x;
                  rsp_in.entry_y     = best_point.y;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         sc_ff        <= '0;
         drain_ff     <= 1'b0;
         pend_find_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         sc_ff        <= sc_in;
         drain_ff     <= drain_in;
         pend_find_ff <= pend_find_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // hold the query position for the whole scan
   always_ff @(posedge clock) begin
      pend_status_ff <= pend_status_in;
      rsp_ff         <= rsp_in;
      if (req_accept) begin
         qx_ff <= req_data.pos_x;
         qy_ff <= req_data.pos_y;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
